[hw/rtl/efc_pkg.sv]
// Shared constants, codes and the arctangent table of the fly-camera engine.
// Used by euler_fly_camera_update; no dependencies.
package efc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ZOOM_RESET_DEF   = 2949120;

    // Angles in degrees Q9.16, carried on a 36-bit signed working width
    localparam logic signed [35:0] DEG90     = 36'sd5898240;
    localparam logic signed [35:0] DEG180    = 36'sd11796480;
    localparam logic signed [35:0] DEG360    = 36'sd23592960;
    localparam logic signed [35:0] PITCH_LIM = 36'sd5832704;
    localparam logic signed [35:0] WRAP_BIAS = 36'sd3019898880;   // 128 turns

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;  // Q30

    // Register reset values
    localparam logic [15:0]        SPEED_RST = 16'd640;
    localparam logic [15:0]        SENS_RST  = 16'd6554;
    localparam logic signed [15:0] WUP_X_RST = 16'sd0;
    localparam logic signed [15:0] WUP_Y_RST = 16'sd16384;
    localparam logic signed [15:0] WUP_Z_RST = 16'sd0;
    localparam logic signed [24:0] YAW_RST   = -25'sd5898240;
    localparam logic signed [24:0] PITCH_RST = 25'sd0;

    // Register indexes
    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_SENS  = 3'd1;
    localparam logic [2:0] REG_WUP_X = 3'd2;
    localparam logic [2:0] REG_WUP_Y = 3'd3;
    localparam logic [2:0] REG_WUP_Z = 3'd4;

    // Request modes and move directions
    localparam logic [1:0] MODE_MOVE = 2'd0;
    localparam logic [1:0] MODE_LOOK = 2'd1;
    localparam logic [1:0] MODE_ZOOM = 2'd2;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // arctan(2^-i) in degrees Q.16
    function automatic logic [21:0] atan_deg(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/euler_fly_camera_update.sv]
// Look makes two CORDIC runs and three normalizations on the shared multiplier and the
// bit-serial square root and divider. One request at a time; the next is taken once the
// result sits in the output register. After reset the engine builds front and up from
// the start angles with input stalled and config not ready.
// Fly-camera state engine: one sequencer around a shared multiplier.
// Depends on efc_pkg.
module euler_fly_camera_update
    import efc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ZOOM_RESET   = ZOOM_RESET_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_direction,
    input  logic [15:0]        i_delta_time,
    input  logic signed [15:0] i_x_offset,
    input  logic signed [15:0] i_y_offset,
    input  logic               i_constrain_pitch,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic signed [24:0] o_yaw_out,
    output logic signed [24:0] o_pitch_out,
    output logic [23:0]        o_zoom_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [24:0]        i_cfg_data
);

    localparam int CntW = $clog2(CORDIC_STEPS);

    typedef enum logic [5:0] {
        S_IDLE, S_DONE,
        S_LK_X, S_LK_YAW, S_LK_YAWD, S_LK_PIT, S_LK_PITD,
        S_WR_NEG, S_WR_SUB,
        S_SC_MUL, S_SC_Z,
        S_MV_V, S_MV_V2, S_MV_NF, S_MV_CR, S_MV_ND, S_MV_P, S_MV_A,
        S_RB, S_RB_C1, S_RB_C2, S_RB_F0, S_RB_F2, S_RB_NF, S_RB_CR1, S_RB_NR,
        S_RB_CR2, S_RB_NU,
        S_CD_PRE, S_CD_IT, S_CD_END,
        S_NM_GO, S_NM_SQ, S_NM_AC, S_NM_RT, S_NM_DV0, S_NM_DV, S_NM_DVE,
        S_CR_GO, S_CR_MUL, S_CR_ACC
    } t_state;

    t_state r_state, r_ret;
    logic   r_boot, r_ovalid;

    // configuration
    logic [15:0]        r_speed, r_sens;
    logic signed [15:0] r_wu [3];

    // camera state
    logic [31:0]        r_pos [3];
    logic signed [24:0] r_yaw, r_pitch;
    logic [23:0]        r_zoom;
    logic signed [15:0] r_front [3];
    logic signed [15:0] r_up [3];

    // captured request
    logic [1:0]         r_dir;
    logic [15:0]        r_dt;
    logic signed [15:0] r_xo, r_yo;
    logic               r_cons;

    // working registers
    logic signed [65:0] r_prod;
    logic signed [35:0] r_w;
    logic [2:0]         r_cnt;
    logic signed [24:0] r_ang;
    logic signed [32:0] r_cx, r_cy, r_c1, r_s1;
    logic signed [25:0] r_cz;
    logic               r_cneg;
    logic [CntW-1:0]    r_ccnt;
    logic signed [32:0] r_vec [3];
    logic signed [15:0] r_nout [3];
    logic signed [15:0] r_ca [3];
    logic signed [15:0] r_cb [3];
    logic signed [15:0] r_d [3];
    logic signed [32:0] r_ctmp;
    logic [63:0]        r_acc, r_root, r_bit;
    logic [48:0]        r_rem;
    logic [14:0]        r_q;
    logic [3:0]         r_bc;
    logic [31:0]        r_v;

    // output register
    logic [31:0]        r_o_pos [3];
    logic signed [15:0] r_o_front [3];
    logic signed [15:0] r_o_up [3];
    logic signed [24:0] r_o_yaw, r_o_pitch;
    logic [23:0]        r_o_zoom;

    // combinational datapath
    logic signed [32:0] mul_a, mul_b;
    logic [1:0]         cr_ai, cr_bi;
    logic signed [35:0] prod36, yaw36, pitch36, zoom36, lk_pa, lk_pc, sc_z, cd_a, wr_trial;
    logic signed [32:0] cd_shx, cd_shy;
    logic signed [25:0] cd_atan;
    logic [32:0]        nm_mag;
    logic [48:0]        nm_trial;
    logic [63:0]        nm_sum;
    logic signed [65:0] mv_t;
    logic [31:0]        mv_delta;
    logic [1:0]         k2;

    assign k2       = r_cnt[1:0];
    assign prod36   = $signed(r_prod[35:0]);
    assign yaw36    = $signed({{11{r_yaw[24]}}, r_yaw});
    assign pitch36  = $signed({{11{r_pitch[24]}}, r_pitch});
    assign zoom36   = $signed({12'b0, r_zoom});
    assign cd_a     = $signed({{11{r_ang[24]}}, r_ang});
    assign cd_shx   = r_cx >>> r_ccnt;
    assign cd_shy   = r_cy >>> r_ccnt;
    assign cd_atan  = $signed({4'b0, atan_deg(5'(r_ccnt))});
    assign wr_trial = DEG360 <<< r_cnt;
    assign nm_sum   = r_root + r_bit;
    assign nm_mag   = r_vec[k2][32] ? 33'(-r_vec[k2]) : 33'(r_vec[k2]);
    assign nm_trial = {15'b0, r_root[32:0], 1'b0} << r_bc;
    assign mv_t     = r_prod + 66'sd2097152;
    assign mv_delta = mv_t[53:22];

    always_comb begin
        lk_pa = pitch36 + prod36;
        lk_pc = lk_pa;
        if (r_cons) begin
            if (lk_pa > PITCH_LIM) lk_pc = PITCH_LIM;
            if (lk_pa < -PITCH_LIM) lk_pc = -PITCH_LIM;
        end
        sc_z = zoom36 - prod36;
        if (sc_z > DEG180) sc_z = DEG180;
        if (sc_z < 36'sd0) sc_z = 36'sd0;
    end

    // cross product term order: o[k] = a[k+1]*b[k+2] - a[k+2]*b[k+1]
    always_comb begin
        case (r_cnt)
            3'd0:    begin cr_ai = 2'd1; cr_bi = 2'd2; end
            3'd1:    begin cr_ai = 2'd2; cr_bi = 2'd1; end
            3'd2:    begin cr_ai = 2'd2; cr_bi = 2'd0; end
            3'd3:    begin cr_ai = 2'd0; cr_bi = 2'd2; end
            3'd4:    begin cr_ai = 2'd0; cr_bi = 2'd1; end
            3'd5:    begin cr_ai = 2'd1; cr_bi = 2'd0; end
            default: begin cr_ai = 2'd0; cr_bi = 2'd0; end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_LK_X: begin
                mul_a = $signed({{17{r_xo[15]}}, r_xo});
                mul_b = $signed({17'b0, r_sens});
            end
            S_LK_YAWD, S_SC_MUL: begin
                mul_a = $signed({{17{r_yo[15]}}, r_yo});
                mul_b = $signed({17'b0, r_sens});
            end
            S_MV_V: begin
                mul_a = $signed({17'b0, r_speed});
                mul_b = $signed({17'b0, r_dt});
            end
            S_MV_P: begin
                mul_a = $signed({1'b0, r_v});
                mul_b = $signed({{17{r_d[k2][15]}}, r_d[k2]});
            end
            S_RB_C2: begin
                mul_a = r_c1;
                mul_b = r_cx;
            end
            S_RB_F0: begin
                mul_a = r_s1;
                mul_b = r_cx;
            end
            S_NM_SQ: begin
                mul_a = r_vec[k2];
                mul_b = r_vec[k2];
            end
            S_CR_MUL: begin
                mul_a = $signed({{17{r_ca[cr_ai][15]}}, r_ca[cr_ai]});
                mul_b = $signed({{17{r_cb[cr_bi][15]}}, r_cb[cr_bi]});
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RB;
            r_ret    <= S_IDLE;
            r_boot   <= 1'b1;
            r_ovalid <= 1'b0;
            r_speed  <= SPEED_RST;
            r_sens   <= SENS_RST;
            r_wu[0]  <= WUP_X_RST;
            r_wu[1]  <= WUP_Y_RST;
            r_wu[2]  <= WUP_Z_RST;
            r_pos[0] <= 32'd0;
            r_pos[1] <= 32'd0;
            r_pos[2] <= 32'd0;
            r_yaw    <= YAW_RST;
            r_pitch  <= PITCH_RST;
            r_zoom   <= 24'(ZOOM_RESET);
        end else begin
            if (r_ovalid && !i_out_stall && r_state != S_DONE) r_ovalid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SPEED: r_speed <= i_cfg_data[15:0];
                    REG_SENS:  r_sens  <= i_cfg_data[15:0];
                    REG_WUP_X: r_wu[0] <= $signed(i_cfg_data[15:0]);
                    REG_WUP_Y: r_wu[1] <= $signed(i_cfg_data[15:0]);
                    REG_WUP_Z: r_wu[2] <= $signed(i_cfg_data[15:0]);
                    default: ;  // start angles act at reset only
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dir  <= i_direction;
                        r_dt   <= i_delta_time;
                        r_xo   <= i_x_offset;
                        r_yo   <= i_y_offset;
                        r_cons <= i_constrain_pitch;
                        case (i_mode)
                            MODE_MOVE: r_state <= S_MV_V;
                            MODE_LOOK: r_state <= S_LK_X;
                            MODE_ZOOM: r_state <= S_SC_MUL;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end

                // ---- look ----
                S_LK_X: r_state <= S_LK_YAW;
                S_LK_YAW: begin
                    r_w     <= yaw36 + prod36 + DEG180;
                    r_ret   <= S_LK_YAWD;
                    r_state <= S_WR_NEG;
                end
                S_LK_YAWD: begin
                    r_yaw   <= 25'(r_w - DEG180);
                    r_state <= S_LK_PIT;
                end
                S_LK_PIT: begin
                    r_w     <= lk_pc + DEG180;
                    r_ret   <= S_LK_PITD;
                    r_state <= S_WR_NEG;
                end
                S_LK_PITD: begin
                    r_pitch <= 25'(r_w - DEG180);
                    r_state <= S_RB;
                end

                // ---- wrap r_w into [0, 360) ----
                S_WR_NEG: begin
                    if (r_w[35]) r_w <= r_w + WRAP_BIAS;
                    r_cnt   <= 3'd7;
                    r_state <= S_WR_SUB;
                end
                S_WR_SUB: begin
                    if (r_w >= wr_trial) r_w <= r_w - wr_trial;
                    if (r_cnt == 3'd0) r_state <= r_ret;
                    else r_cnt <= r_cnt - 3'd1;
                end

                // ---- scroll ----
                S_SC_MUL: r_state <= S_SC_Z;
                S_SC_Z: begin
                    r_zoom  <= sc_z[23:0];
                    r_state <= S_DONE;
                end

                // ---- move ----
                S_MV_V: r_state <= S_MV_V2;
                S_MV_V2: begin
                    r_v      <= r_prod[31:0];
                    r_vec[0] <= $signed({{17{r_front[0][15]}}, r_front[0]});
                    r_vec[1] <= $signed({{17{r_front[1][15]}}, r_front[1]});
                    r_vec[2] <= $signed({{17{r_front[2][15]}}, r_front[2]});
                    r_ret    <= S_MV_NF;
                    r_state  <= S_NM_GO;
                end
                S_MV_NF: begin
                    r_front <= r_nout;
                    if (r_dir inside {DIR_FWD, DIR_BACK}) begin
                        r_d     <= r_nout;
                        r_cnt   <= 3'd0;
                        r_state <= S_MV_P;
                    end else begin
                        r_ca    <= r_nout;
                        r_cb    <= r_up;
                        r_ret   <= S_MV_CR;
                        r_state <= S_CR_GO;
                    end
                end
                S_MV_CR: begin
                    r_ret   <= S_MV_ND;
                    r_state <= S_NM_GO;
                end
                S_MV_ND: begin
                    r_d     <= r_nout;
                    r_cnt   <= 3'd0;
                    r_state <= S_MV_P;
                end
                S_MV_P: r_state <= S_MV_A;
                S_MV_A: begin
                    if (r_dir inside {DIR_BACK, DIR_LEFT}) r_pos[k2] <= r_pos[k2] - mv_delta;
                    else r_pos[k2] <= r_pos[k2] + mv_delta;
                    if (r_cnt == 3'd2) r_state <= S_DONE;
                    else begin
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_MV_P;
                    end
                end

                // ---- rebuild front, right, up ----
                S_RB: begin
                    r_ang   <= r_yaw;
                    r_ret   <= S_RB_C1;
                    r_state <= S_CD_PRE;
                end
                S_RB_C1: begin
                    r_c1    <= r_cx;
                    r_s1    <= r_cy;
                    r_ang   <= r_pitch;
                    r_ret   <= S_RB_C2;
                    r_state <= S_CD_PRE;
                end
                S_RB_C2: r_state <= S_RB_F0;
                S_RB_F0: begin
                    r_vec[0] <= 33'(r_prod >>> 30);
                    r_state  <= S_RB_F2;
                end
                S_RB_F2: begin
                    r_vec[1] <= r_cy;
                    r_vec[2] <= 33'(r_prod >>> 30);
                    r_ret    <= S_RB_NF;
                    r_state  <= S_NM_GO;
                end
                S_RB_NF: begin
                    r_front <= r_nout;
                    r_ca    <= r_nout;
                    r_cb    <= r_wu;
                    r_ret   <= S_RB_CR1;
                    r_state <= S_CR_GO;
                end
                S_RB_CR1: begin
                    r_ret   <= S_RB_NR;
                    r_state <= S_NM_GO;
                end
                S_RB_NR: begin
                    r_ca    <= r_nout;
                    r_cb    <= r_front;
                    r_ret   <= S_RB_CR2;
                    r_state <= S_CR_GO;
                end
                S_RB_CR2: begin
                    r_ret   <= S_RB_NU;
                    r_state <= S_NM_GO;
                end
                S_RB_NU: begin
                    r_up <= r_nout;
                    if (r_boot) begin
                        r_boot  <= 1'b0;
                        r_state <= S_IDLE;
                    end else r_state <= S_DONE;
                end

                // ---- CORDIC rotation, angle folded into +-90 ----
                S_CD_PRE: begin
                    if (cd_a > DEG90) begin
                        r_cz   <= 26'(cd_a - DEG180);
                        r_cneg <= 1'b1;
                    end else if (cd_a < -DEG90) begin
                        r_cz   <= 26'(cd_a + DEG180);
                        r_cneg <= 1'b1;
                    end else begin
                        r_cz   <= 26'(cd_a);
                        r_cneg <= 1'b0;
                    end
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= 33'sd0;
                    r_ccnt  <= '0;
                    r_state <= S_CD_IT;
                end
                S_CD_IT: begin
                    if (!r_cz[25]) begin
                        r_cx <= r_cx - cd_shy;
                        r_cy <= r_cy + cd_shx;
                        r_cz <= r_cz - cd_atan;
                    end else begin
                        r_cx <= r_cx + cd_shy;
                        r_cy <= r_cy - cd_shx;
                        r_cz <= r_cz + cd_atan;
                    end
                    if (r_ccnt == CntW'(CORDIC_STEPS - 1)) r_state <= S_CD_END;
                    else r_ccnt <= r_ccnt + CntW'(1);
                end
                S_CD_END: begin
                    if (r_cneg) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                    r_state <= r_ret;
                end

                // ---- normalize r_vec into r_nout ----
                S_NM_GO: begin
                    r_acc   <= 64'd0;
                    r_cnt   <= 3'd0;
                    r_state <= S_NM_SQ;
                end
                S_NM_SQ: r_state <= S_NM_AC;
                S_NM_AC: begin
                    r_acc <= r_acc + r_prod[63:0];
                    if (r_cnt == 3'd2) begin
                        r_root  <= 64'd0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= S_NM_RT;
                    end else begin
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_NM_SQ;
                    end
                end
                S_NM_RT: begin
                    if (r_acc >= nm_sum) begin
                        r_acc  <= r_acc - nm_sum;
                        r_root <= (r_root >> 1) + r_bit;
                    end else r_root <= r_root >> 1;
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_cnt   <= 3'd0;
                        r_state <= S_NM_DV0;
                    end
                end
                S_NM_DV0: begin
                    if (r_root == 64'd0) begin
                        r_nout[k2] <= 16'sd0;
                        if (r_cnt == 3'd2) r_state <= r_ret;
                        else r_cnt <= r_cnt + 3'd1;
                    end else begin
                        // round half up: ((m << 15) + s) / 2s
                        r_rem   <= {1'b0, nm_mag, 15'b0} + {16'b0, r_root[32:0]};
                        r_q     <= 15'd0;
                        r_bc    <= 4'd14;
                        r_state <= S_NM_DV;
                    end
                end
                S_NM_DV: begin
                    if (r_rem >= nm_trial) begin
                        r_rem <= r_rem - nm_trial;
                        r_q   <= {r_q[13:0], 1'b1};
                    end else r_q <= {r_q[13:0], 1'b0};
                    if (r_bc == 4'd0) r_state <= S_NM_DVE;
                    else r_bc <= r_bc - 4'd1;
                end
                S_NM_DVE: begin
                    if (r_vec[k2][32]) r_nout[k2] <= -$signed({1'b0, r_q});
                    else r_nout[k2] <= $signed({1'b0, r_q});
                    if (r_cnt == 3'd2) r_state <= r_ret;
                    else begin
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_NM_DV0;
                    end
                end

                // ---- cross product r_ca x r_cb into r_vec ----
                S_CR_GO: begin
                    r_cnt   <= 3'd0;
                    r_state <= S_CR_MUL;
                end
                S_CR_MUL: r_state <= S_CR_ACC;
                S_CR_ACC: begin
                    if (!r_cnt[0]) r_ctmp <= $signed(r_prod[32:0]);
                    else r_vec[r_cnt[2:1]] <= r_ctmp - $signed(r_prod[32:0]);
                    if (r_cnt == 3'd5) r_state <= r_ret;
                    else begin
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_CR_MUL;
                    end
                end

                // hold until the output register is free
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_o_pos   <= r_pos;
                        r_o_front <= r_front;
                        r_o_up    <= r_up;
                        r_o_yaw   <= r_yaw;
                        r_o_pitch <= r_pitch;
                        r_o_zoom  <= r_zoom;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_pos_x     = $signed(r_o_pos[0]);
    assign o_pos_y     = $signed(r_o_pos[1]);
    assign o_pos_z     = $signed(r_o_pos[2]);
    assign o_front_x   = r_o_front[0];
    assign o_front_y   = r_o_front[1];
    assign o_front_z   = r_o_front[2];
    assign o_up_x      = r_o_up[0];
    assign o_up_y      = r_o_up[1];
    assign o_up_z      = r_o_up[2];
    assign o_yaw_out   = r_o_yaw;
    assign o_pitch_out = r_o_pitch;
    assign o_zoom_out  = r_o_zoom;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("engine not busy after accepting a request");

    a_norm_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NM_DVE) |-> (r_q <= 15'd16384))
        else $error("normalized component above one");

    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LK_YAWD || r_state == S_LK_PITD) |-> (r_w >= 36'sd0 && r_w < DEG360))
        else $error("angle wrap out of range");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_yaw >= -DEG180) && (r_yaw < DEG180))
        else $error("yaw outside one turn");

    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zoom <= 24'd11796480)
        else $error("zoom above 180 degrees");

endmodule

[bench/tb_top.sv]
// Self-checking bench for euler_fly_camera_update: directed and random requests
// against a bit-exact fixed-point camera predictor, with random stalls on both sides.
// Depends on efc_pkg and the euler_fly_camera_update RTL.
module tb_top
    import efc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_START_YAW   = 3'd5;
    localparam logic [2:0] REG_START_PITCH = 3'd6;
    localparam logic [2:0] REG_NONE        = 3'd7;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    localparam longint A90   = 64'sd5898240;
    localparam longint A180  = 64'sd11796480;
    localparam longint A360  = 64'sd23592960;
    localparam longint ALIM  = 64'sd5832704;
    localparam longint GAIN  = 64'sd652032874;
    localparam int     STEPS = 16;

    localparam longint ARCTAN [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    typedef longint t_vec3 [3];
    typedef struct {
        logic [31:0] px, py, pz;
        logic signed [15:0] fx, fy, fz, ux, uy, uz;
        logic signed [24:0] yaw, pitch;
        logic [23:0] zoom;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_mode = '0;
    logic [1:0]         i_direction = '0;
    logic [15:0]        i_delta_time = '0;
    logic signed [15:0] i_x_offset = '0;
    logic signed [15:0] i_y_offset = '0;
    logic               i_constrain_pitch = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_front_x, o_front_y, o_front_z, o_up_x, o_up_y, o_up_z;
    logic signed [24:0] o_yaw_out, o_pitch_out;
    logic [23:0]        o_zoom_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [24:0]        i_cfg_data = '0;

    euler_fly_camera_update uut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [24:0] cam_reg [7];
    logic [31:0] cam_pos [3];
    longint      cam_yaw, cam_pitch, cam_zoom;
    t_vec3       cam_front, cam_up;

    t_pose pose_q [$];
    int    errors = 0;
    bit    idle_on = 1'b1;
    int    hold_cycles = 0;
    int    stall_left = 0;

    function automatic longint wrap_angle(input longint a);
        longint r;
        r = (a + A180) % A360;
        if (r < 0) r += A360;
        return r - A180;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void cordic_rot(input longint a, output longint c, output longint s);
        longint x, y, z, t;
        bit neg;
        x = GAIN;
        y = 0;
        neg = 1'b0;
        a = wrap_angle(a);
        if (a > A90) begin
            a -= A180;
            neg = 1'b1;
        end else if (a < -A90) begin
            a += A180;
            neg = 1'b1;
        end
        z = a;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ARCTAN[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += ARCTAN[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic void unit3(input t_vec3 v, output t_vec3 o);
        logic [63:0] l, s, m, q;
        l = 0;
        for (int k = 0; k < 3; k++) l += v[k] * v[k];
        s = isqrt(l);
        for (int k = 0; k < 3; k++) begin
            if (s == 0) begin
                o[k] = 0;
            end else begin
                m = (v[k] < 0) ? -v[k] : v[k];
                q = ((m << 15) + s) / (2 * s);
                o[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    function automatic void cross3(input t_vec3 a, input t_vec3 b, output t_vec3 o);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void rebuild_basis();
        longint cy, sy, cp, sp;
        t_vec3 f, wu, t, rt;
        cordic_rot(cam_yaw, cy, sy);
        cordic_rot(cam_pitch, cp, sp);
        f[0] = (cy * cp) >>> 30;
        f[1] = sp;
        f[2] = (sy * cp) >>> 30;
        unit3(f, cam_front);
        for (int k = 0; k < 3; k++) wu[k] = longint'($signed(cam_reg[REG_WUP_X + k][15:0]));
        cross3(cam_front, wu, t);
        unit3(t, rt);
        cross3(rt, cam_front, t);
        unit3(t, cam_up);
    endfunction

    function automatic void reset_camera();
        cam_reg[REG_SPEED] = 25'(SPEED_RST);
        cam_reg[REG_SENS]  = 25'(SENS_RST);
        cam_reg[REG_WUP_X] = 25'(WUP_X_RST) & 25'hFFFF;
        cam_reg[REG_WUP_Y] = 25'(WUP_Y_RST) & 25'hFFFF;
        cam_reg[REG_WUP_Z] = 25'(WUP_Z_RST) & 25'hFFFF;
        cam_reg[REG_START_YAW]   = YAW_RST;
        cam_reg[REG_START_PITCH] = 25'(PITCH_RST) & 25'hFFFFFF;
        for (int k = 0; k < 3; k++) cam_pos[k] = '0;
        cam_yaw   = wrap_angle(longint'($signed(cam_reg[REG_START_YAW])));
        cam_pitch = wrap_angle(longint'($signed(cam_reg[REG_START_PITCH][23:0])));
        cam_zoom  = ZOOM_RESET_DEF;
        rebuild_basis();
    endfunction

    function automatic t_pose predict_pose(input logic [1:0] mode, input logic [1:0] dir,
                                           input logic [15:0] dt, input logic signed [15:0] xo,
                                           input logic signed [15:0] yo, input logic cons);
        t_pose p;
        longint sens, v, pa, z;
        t_vec3 d, t;
        logic [31:0] delta;
        sens = longint'(cam_reg[REG_SENS][15:0]);
        case (mode)
            MODE_MOVE: begin
                v = longint'(cam_reg[REG_SPEED][15:0]) * longint'(dt);
                t = cam_front;
                unit3(t, cam_front);
                if (dir == DIR_FWD || dir == DIR_BACK) begin
                    d = cam_front;
                end else begin
                    cross3(cam_front, cam_up, t);
                    unit3(t, d);
                end
                for (int k = 0; k < 3; k++) begin
                    delta = 32'((v * d[k] + (64'sd1 <<< 21)) >>> 22);
                    if (dir == DIR_BACK || dir == DIR_LEFT) cam_pos[k] -= delta;
                    else cam_pos[k] += delta;
                end
            end
            MODE_LOOK: begin
                pa = cam_pitch + longint'(yo) * sens;
                cam_yaw = wrap_angle(cam_yaw + longint'(xo) * sens);
                if (cons) begin
                    if (pa > ALIM) pa = ALIM;
                    if (pa < -ALIM) pa = -ALIM;
                end
                cam_pitch = wrap_angle(pa);
                rebuild_basis();
            end
            MODE_ZOOM: begin
                z = cam_zoom - longint'(yo) * sens;
                if (z > A180) z = A180;
                if (z < 0) z = 0;
                cam_zoom = z;
            end
            default: ;
        endcase
        p.px = cam_pos[0]; p.py = cam_pos[1]; p.pz = cam_pos[2];
        p.fx = cam_front[0][15:0]; p.fy = cam_front[1][15:0]; p.fz = cam_front[2][15:0];
        p.ux = cam_up[0][15:0]; p.uy = cam_up[1][15:0]; p.uz = cam_up[2][15:0];
        p.yaw = cam_yaw[24:0]; p.pitch = cam_pitch[24:0]; p.zoom = cam_zoom[23:0];
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // receiver: check each accepted result, then choose the stall for the next cycle
    always @(posedge i_clk) begin
        t_pose e;
        if (o_out_valid && !i_out_stall) begin
            if (pose_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = pose_q.pop_front();
                check_field("pos_x", e.px, o_pos_x);
                check_field("pos_y", e.py, o_pos_y);
                check_field("pos_z", e.pz, o_pos_z);
                check_field("front_x", e.fx, o_front_x);
                check_field("front_y", e.fy, o_front_y);
                check_field("front_z", e.fz, o_front_z);
                check_field("up_x", e.ux, o_up_x);
                check_field("up_y", e.uy, o_up_y);
                check_field("up_z", e.uz, o_up_z);
                check_field("yaw_out", e.yaw, o_yaw_out);
                check_field("pitch_out", e.pitch, o_pitch_out);
                check_field("zoom_out", e.zoom, o_zoom_out);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_request(input logic [1:0] mode, input logic [1:0] dir,
                                input logic [15:0] dt, input logic signed [15:0] xo,
                                input logic signed [15:0] yo, input logic cons);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= mode;
        i_direction       <= dir;
        i_delta_time      <= dt;
        i_x_offset        <= xo;
        i_y_offset        <= yo;
        i_constrain_pitch <= cons;
        do @(posedge i_clk); while (o_in_stall);
        pose_q.push_back(predict_pose(mode, dir, dt, xo, yo, cons));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [24:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_START_YAW) cam_reg[idx] = data;
        else if (idx == REG_START_PITCH) cam_reg[idx] = data & 25'hFFFFFF;
        else if (idx != REG_NONE) cam_reg[idx] = data & 25'hFFFF;
    endtask

    task automatic set_camera_regs(input logic [15:0] speed, input logic [15:0] sens,
                                   input logic [15:0] ux, input logic [15:0] uy,
                                   input logic [15:0] uz);
        drain();
        write_reg(REG_SPEED, 25'(speed));
        write_reg(REG_SENS, 25'(sens));
        write_reg(REG_WUP_X, 25'(ux));
        write_reg(REG_WUP_Y, 25'(uy));
        write_reg(REG_WUP_Z, 25'(uz));
    endtask

    task automatic send_random();
        int pick;
        logic signed [15:0] xo, yo;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 2) == 0) begin
            xo = 16'($urandom);
            yo = 16'($urandom);
        end else begin
            xo = 16'(int'($urandom_range(0, 400)) - 200);
            yo = 16'(int'($urandom_range(0, 400)) - 200);
        end
        send_request(pick < 40 ? MODE_MOVE : pick < 75 ? MODE_LOOK :
                     pick < 95 ? MODE_ZOOM : MODE_UNUSED,
                     2'($urandom), 16'($urandom), xo, yo, 1'($urandom));
    endtask

    task automatic test_moves();
        for (int d = 0; d < 4; d++) begin
            send_request(MODE_MOVE, d[1:0], 16'hFFFF, '0, '0, 1'b0);
            send_request(MODE_MOVE, d[1:0], 16'h0000, 16'sh7FFF, -16'sh8000, 1'b1);
        end
    endtask

    task automatic test_look();
        send_request(MODE_LOOK, DIR_FWD, '0, 16'sd300, 16'sd400, 1'b1);
        send_request(MODE_LOOK, DIR_FWD, '0, -16'sh8000, 16'sh7FFF, 1'b1);
        send_request(MODE_LOOK, DIR_FWD, '0, 16'sh7FFF, -16'sh8000, 1'b1);
        send_request(MODE_LOOK, DIR_FWD, '0, 16'sd10, 16'sh7FFF, 1'b0);
        send_request(MODE_LOOK, DIR_FWD, '0, -16'sd10, -16'sh8000, 1'b0);
        send_request(MODE_MOVE, DIR_LEFT, 16'h8000, '0, '0, 1'b0);
    endtask

    task automatic test_zoom();
        send_request(MODE_ZOOM, DIR_FWD, '0, '0, 16'sd20, 1'b0);
        send_request(MODE_ZOOM, DIR_FWD, '0, '0, 16'sh7FFF, 1'b0);
        send_request(MODE_ZOOM, DIR_FWD, '0, '0, -16'sh8000, 1'b0);
        send_request(MODE_ZOOM, DIR_FWD, '0, '0, -16'sd40, 1'b0);
    endtask

    task automatic test_unused_mode();
        send_request(MODE_UNUSED, DIR_RIGHT, 16'hFFFF, -16'sd1, -16'sd1, 1'b1);
    endtask

    // front straight down the world up axis, then a zero world up
    task automatic test_degenerate_basis();
        set_camera_regs(16'hFFFF, 16'd180, 16'd0, 16'd16384, 16'd0);
        send_request(MODE_LOOK, DIR_FWD, '0, '0, -16'sh8000, 1'b0);
        send_request(MODE_MOVE, DIR_RIGHT, 16'hFFFF, '0, '0, 1'b0);
        set_camera_regs(16'd640, 16'd6554, 16'd0, 16'd0, 16'd0);
        send_request(MODE_LOOK, DIR_FWD, '0, 16'sd50, 16'sd50, 1'b1);
        send_request(MODE_MOVE, DIR_LEFT, 16'hFFFF, '0, '0, 1'b0);
        send_request(MODE_MOVE, DIR_BACK, 16'hFFFF, '0, '0, 1'b0);
    endtask

    // start angles act only at reset; the write must leave yaw and pitch alone
    task automatic test_start_regs();
        drain();
        write_reg(REG_START_YAW, 25'h1FFFFFF);
        write_reg(REG_START_PITCH, 25'h0FFFFFF);
        write_reg(REG_NONE, 25'h1ABCDEF);
        send_request(MODE_ZOOM, DIR_FWD, '0, '0, 16'sd1, 1'b0);
    endtask

    task automatic test_backpressure();
        bit saved;
        drain();
        saved = idle_on;
        idle_on = 1'b0;
        hold_cycles = 600;
        for (int n = 0; n < 8; n++) send_request(MODE_ZOOM, DIR_FWD, '0, '0, -16'sd3, 1'b0);
        for (int n = 0; n < 4; n++) send_request(MODE_MOVE, n[1:0], 16'd500, '0, '0, 1'b0);
        idle_on = saved;
    endtask

    task automatic test_random();
        set_camera_regs(16'd640, 16'd6554, 16'd0, 16'd16384, 16'd0);
        repeat (350) send_random();
        set_camera_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'h4000, 16'h7FFF);
        repeat (300) send_random();
        set_camera_regs(16'd0, 16'd0, 16'hC000, 16'd0, 16'd16384);
        repeat (150) send_random();
        set_camera_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        repeat (350) send_random();
        set_camera_regs(16'd2000, 16'd3000, 16'd11585, 16'd11585, 16'd0);
        repeat (300) send_random();
        idle_on = 1'b0;
        repeat (120) send_random();
    endtask

    initial begin
        reset_camera();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_moves();
        test_look();
        test_zoom();
        test_unused_mode();
        test_degenerate_basis();
        test_start_regs();
        test_backpressure();
        test_random();
        drain();
        repeat (500) @(posedge i_clk);
        if (errors == 0) $display("[euler_fly_camera_update] OK");
        else $display("[euler_fly_camera_update] ERROR");
        $finish;
    end

    initial begin
        #40ms;
        $display("[euler_fly_camera_update] ERROR");
        $finish;
    end

endmodule
